@@ design/mp_pkg.sv @@
// ----------------------------------------------------------------------------
// Meshlet packer package
// Shared types, codes and reset values of the meshlet packer.
// ----------------------------------------------------------------------------
package mp_pkg;

   // Fixed field widths of the channels.
   localparam int VERT_W      = 32;
   localparam int SLOT_OUT_W  = 6;
   localparam int VCOUNT_W    = 7;
   localparam int PCOUNT_W    = 8;
   localparam int NUMBER_W    = 16;
   localparam int CSR_DATA_W  = 8;

   // Limit registers after reset.
   localparam logic [VCOUNT_W-1:0] VERTEX_LIMIT_RESET    = 7'd64;
   localparam logic [PCOUNT_W-1:0] PRIMITIVE_LIMIT_RESET = 8'd126;

   // What an input beat asks for.
   typedef enum logic {
      ACT_TRIANGLE = 1'b0,
      ACT_FLUSH    = 1'b1
   } action_type;

   // What a result beat carries.
   typedef enum logic [1:0] {
      KIND_VERTEX = 2'd0,
      KIND_PRIM   = 2'd1,
      KIND_CLOSE  = 2'd2
   } kind_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_VERTEX_LIMIT    = 1'b0,
      CSR_PRIMITIVE_LIMIT = 1'b1
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_CLOSE,
      ST_VERT,
      ST_PRIM,
      ST_FLUSH
   } state_type;

   // One result beat.
   typedef struct packed {
      kind_type                kind;
      logic [SLOT_OUT_W-1:0]   slot;
      logic [VERT_W-1:0]       vertex_index;
      logic [SLOT_OUT_W-1:0]   local_a;
      logic [SLOT_OUT_W-1:0]   local_b;
      logic [SLOT_OUT_W-1:0]   local_c;
      logic [VCOUNT_W-1:0]     vertex_count;
      logic [PCOUNT_W-1:0]     primitive_count;
      logic [NUMBER_W-1:0]     meshlet_number;
      logic                    last;
   } rsp_beat_type;

endpackage

@@ design/mp_chan_if.sv @@
// ----------------------------------------------------------------------------
// Meshlet packer channels
// Valid/ready interfaces for the triangle input and the result output.
// ----------------------------------------------------------------------------

// Input channel: one triangle or one flush per beat.
interface mp_req_if
   import mp_pkg::*;
();
   logic                valid;
   logic                ready;
   action_type          action;
   logic [VERT_W-1:0]   vert_a;
   logic [VERT_W-1:0]   vert_b;
   logic [VERT_W-1:0]   vert_c;

   modport source (output valid, action, vert_a, vert_b, vert_c, input ready);
   modport sink   (input valid, action, vert_a, vert_b, vert_c, output ready);
   modport monitor (input valid, ready, action, vert_a, vert_b, vert_c);
endinterface

// Result channel: one vertex, primitive or close record per beat.
interface mp_rsp_if
   import mp_pkg::*;
();
   logic                    valid;
   logic                    ready;
   kind_type                kind;
   logic [SLOT_OUT_W-1:0]   slot;
   logic [VERT_W-1:0]       vertex_index;
   logic [SLOT_OUT_W-1:0]   local_a;
   logic [SLOT_OUT_W-1:0]   local_b;
   logic [SLOT_OUT_W-1:0]   local_c;
   logic [VCOUNT_W-1:0]     vertex_count;
   logic [PCOUNT_W-1:0]     primitive_count;
   logic [NUMBER_W-1:0]     meshlet_number;
   logic                    last;

   modport source (output valid, kind, slot, vertex_index, local_a, local_b, local_c,
                   vertex_count, primitive_count, meshlet_number, last, input ready);
   modport sink   (input valid, kind, slot, vertex_index, local_a, local_b, local_c,
                   vertex_count, primitive_count, meshlet_number, last, output ready);
   modport monitor (input valid, ready, kind, slot, vertex_index, local_a, local_b,
                    local_c, vertex_count, primitive_count, meshlet_number, last);
endinterface

@@ design/mp_lookup.sv @@
// ----------------------------------------------------------------------------
// Meshlet packer vertex lookup
// Unique-vertex store of the open meshlet with one compare lane per entry
// and a merge stage that turns the lane matches into a hit and a slot.
// ----------------------------------------------------------------------------
module mp_lookup
   import mp_pkg::*;
#(
   parameter int MAX_VERTS = 64
) (
   input  logic                                 clock,
   input  logic                                 store_we,
   input  logic [$clog2(MAX_VERTS)-1:0]         store_addr,
   input  logic [VERT_W-1:0]                    store_data,
   input  logic [$clog2(MAX_VERTS+1)-1:0]       count,
   input  logic [VERT_W-1:0]                    key,
   output logic                                 hit,
   output logic [$clog2(MAX_VERTS)-1:0]         slot
);

   localparam int SW  = $clog2(MAX_VERTS);
   localparam int VCW = $clog2(MAX_VERTS+1);

   logic [VERT_W-1:0]     store_ff [MAX_VERTS];
   logic [MAX_VERTS-1:0]  match;

   // Store write: one new vertex per beat at the next free slot.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_addr] <= store_data;
      end
   end

   // Compare lanes: each entry below the fill count checks the key.
   for (genvar i = 0; i < MAX_VERTS; i++) begin : g_lane
      assign match[i] = (VCW'(i) < count) && (store_ff[i] == key);
   end

   // Merge: entries are unique, so at most one lane matches.
   always_comb begin
      slot = '0;
      for (int i = 0; i < MAX_VERTS; i++) begin
         if (match[i]) begin
            slot = slot | SW'(i);
         end
      end
   end

   assign hit = |match;

endmodule

@@ design/meshlet_packer_top.sv @@
// ----------------------------------------------------------------------------
// Meshlet packer
// Greedy packing of a triangle stream into meshlets with vertex reuse.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one beat per triangle (three global vertex indices) or
//   one flush beat. rsp_chan returns, per triangle, a beat for each new
//   vertex and then a primitive beat with local slots; a close beat comes
//   first when the triangle does not fit the open meshlet. A flush returns
//   one close beat, or nothing when the open meshlet is empty. The final
//   beat of each input has last set.
//   The sequencer takes a new input only while idle. A triangle then runs
//   three lookups through the compare lanes (one vertex per cycle), one
//   decision, a close step when it closes a meshlet, three vertex steps
//   and one primitive step; a flush runs the flush step. Limits written
//   on csr_* apply from the next decision step on.
//   Reset clears the counts, the meshlet number and the result valid flag
//   and loads the limits 64 and 126. When the receiver stalls, the result
//   register holds its beat and the sequencer waits at its next beat.
// ----------------------------------------------------------------------------
module meshlet_packer_top
   import mp_pkg::*;
#(
   parameter int MAX_VERTS = 64,
   parameter int MAX_PRIMS = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   mp_req_if.sink                   req_chan,
   mp_rsp_if.source                 rsp_chan,
   input  logic                     csr_write_enable,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data
);

   localparam int SW   = $clog2(MAX_VERTS);
   localparam int VCW  = $clog2(MAX_VERTS+1);
   localparam int PCW  = $clog2(MAX_PRIMS+1);
   localparam int VLW  = (VCW > VCOUNT_W) ? VCW : VCOUNT_W;
   localparam int SUMW = VLW + 1;
   localparam int PLW  = (PCW > PCOUNT_W) ? PCW : PCOUNT_W;

   // Control registers.
   state_type               state_ff, state_in;
   logic [1:0]              idx_ff, idx_in;
   logic [VCW-1:0]          vcount_ff, vcount_in;
   logic [PCW-1:0]          pcount_ff, pcount_in;
   logic [NUMBER_W-1:0]     counter_ff, counter_in;
   logic [VCOUNT_W-1:0]     vlim_ff, vlim_in;
   logic [PCOUNT_W-1:0]     plim_ff, plim_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [VERT_W-1:0]       vert_ff [3];
   logic [VERT_W-1:0]       vert_in [3];
   logic [2:0]              hit_ff, hit_in;
   logic [SW-1:0]           lslot_ff [3];
   logic [SW-1:0]           lslot_in [3];
   logic                    closed_ff, closed_in;
   rsp_beat_type            rsp_beat_ff, rsp_beat_in;

   // Lookup connections.
   logic                    store_we;
   logic [VERT_W-1:0]       key;
   logic                    lk_hit;
   logic [SW-1:0]           lk_slot;

   // Sequencer signals.
   logic                    req_fire;
   logic                    out_free;
   logic                    emit;
   rsp_beat_type            beat;
   logic [2:0]              dup;
   logic                    src2;
   logic [1:0]              fresh;
   logic                    close_need;
   logic                    need_new;
   logic [VLW-1:0]          vlim_sat;
   logic [PLW-1:0]          plim_sat;

   mp_lookup #(
      .MAX_VERTS (MAX_VERTS)
   ) u_lookup (
      .clock      (clock),
      .store_we   (store_we),
      .store_addr (vcount_ff[SW-1:0]),
      .store_data (vert_ff[idx_ff]),
      .count      (vcount_ff),
      .key        (key),
      .hit        (lk_hit),
      .slot       (lk_slot)
   );

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign key            = vert_ff[idx_ff];

   // Limits saturated into their legal ranges.
   always_comb begin
      vlim_sat = VLW'(vlim_ff);
      if (VLW'(vlim_ff) < VLW'(3)) begin
         vlim_sat = VLW'(3);
      end else if (VLW'(vlim_ff) > VLW'(MAX_VERTS)) begin
         vlim_sat = VLW'(MAX_VERTS);
      end
      plim_sat = PLW'(plim_ff);
      if (plim_ff == '0) begin
         plim_sat = PLW'(1);
      end else if (PLW'(plim_ff) > PLW'(MAX_PRIMS)) begin
         plim_sat = PLW'(MAX_PRIMS);
      end
   end

   // Repeats inside the triangle and the fit decision.
   always_comb begin
      dup[0]     = 1'b0;
      dup[1]     = (vert_ff[1] == vert_ff[0]);
      dup[2]     = (vert_ff[2] == vert_ff[0]) || (vert_ff[2] == vert_ff[1]);
      src2       = (vert_ff[2] != vert_ff[0]);
      fresh      = 2'(!dup[0] && !hit_ff[0]) + 2'(!dup[1] && !hit_ff[1])
                 + 2'(!dup[2] && !hit_ff[2]);
      close_need = (SUMW'(vcount_ff) + SUMW'(fresh) > SUMW'(vlim_sat))
                || (PLW'(pcount_ff) >= plim_sat);
      need_new   = !dup[idx_ff] && (closed_ff || !hit_ff[idx_ff]);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_chan.action == ACT_FLUSH) ? ST_FLUSH : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (idx_ff == 2'd2) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = close_need ? ST_CLOSE : ST_VERT;
         end
         ST_CLOSE: begin
            if (out_free) begin
               state_in = ST_VERT;
            end
         end
         ST_VERT: begin
            if ((!need_new || out_free) && idx_ff == 2'd2) begin
               state_in = ST_PRIM;
            end
         end
         ST_PRIM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (vcount_ff == '0 || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result beat and store write of the current state.
   always_comb begin
      emit                = 1'b0;
      store_we            = 1'b0;
      beat                = '0;
      beat.meshlet_number = counter_ff;
      case (state_ff)
         ST_CLOSE, ST_FLUSH: begin
            emit                 = out_free && (vcount_ff != '0);
            beat.kind            = KIND_CLOSE;
            beat.vertex_count    = VCOUNT_W'(vcount_ff);
            beat.primitive_count = PCOUNT_W'(pcount_ff);
            beat.last            = (state_ff == ST_FLUSH);
         end
         ST_VERT: begin
            emit              = out_free && need_new;
            store_we          = out_free && need_new;
            beat.kind         = KIND_VERTEX;
            beat.slot         = SLOT_OUT_W'(vcount_ff);
            beat.vertex_index = vert_ff[idx_ff];
         end
         ST_PRIM: begin
            emit         = out_free;
            beat.kind    = KIND_PRIM;
            beat.local_a = SLOT_OUT_W'(lslot_ff[0]);
            beat.local_b = SLOT_OUT_W'(lslot_ff[1]);
            beat.local_c = SLOT_OUT_W'(lslot_ff[2]);
            beat.last    = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Next values of counts, limits, slots and the result register.
   always_comb begin
      idx_in       = idx_ff;
      vcount_in    = vcount_ff;
      pcount_in    = pcount_ff;
      counter_in   = counter_ff;
      vlim_in      = vlim_ff;
      plim_in      = plim_ff;
      vert_in      = vert_ff;
      hit_in       = hit_ff;
      lslot_in     = lslot_ff;
      closed_in    = closed_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
      rsp_beat_in  = emit ? beat : rsp_beat_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_VERTEX_LIMIT:    vlim_in = csr_write_data[VCOUNT_W-1:0];
            CSR_PRIMITIVE_LIMIT: plim_in = csr_write_data;
            default:             vlim_in = vlim_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            idx_in = 2'd0;
            if (req_fire) begin
               vert_in[0] = req_chan.vert_a;
               vert_in[1] = req_chan.vert_b;
               vert_in[2] = req_chan.vert_c;
            end
         end
         ST_LOOKUP: begin
            hit_in[idx_ff]   = lk_hit;
            lslot_in[idx_ff] = lk_slot;
            idx_in           = (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
         end
         ST_DECIDE: begin
            closed_in = close_need;
         end
         ST_CLOSE, ST_FLUSH: begin
            if (emit) begin
               counter_in = counter_ff + 1'b1;
               vcount_in  = '0;
               pcount_in  = '0;
            end
         end
         ST_VERT: begin
            if (!need_new || out_free) begin
               idx_in = (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            end
            if (need_new) begin
               if (out_free) begin
                  lslot_in[idx_ff] = vcount_ff[SW-1:0];
                  vcount_in        = vcount_ff + 1'b1;
               end
            end else if (idx_ff == 2'd1 && dup[1]) begin
               lslot_in[1] = lslot_ff[0];
            end else if (idx_ff == 2'd2 && dup[2]) begin
               lslot_in[2] = src2 ? lslot_ff[1] : lslot_ff[0];
            end
         end
         ST_PRIM: begin
            if (out_free) begin
               pcount_in = pcount_ff + 1'b1;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= 2'd0;
         vcount_ff    <= '0;
         pcount_ff    <= '0;
         counter_ff   <= '0;
         vlim_ff      <= VERTEX_LIMIT_RESET;
         plim_ff      <= PRIMITIVE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         vcount_ff    <= vcount_in;
         pcount_ff    <= pcount_in;
         counter_ff   <= counter_in;
         vlim_ff      <= vlim_in;
         plim_ff      <= plim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      vert_ff     <= vert_in;
      hit_ff      <= hit_in;
      lslot_ff    <= lslot_in;
      closed_ff   <= closed_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   // Result channel.
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.kind            = rsp_beat_ff.kind;
   assign rsp_chan.slot            = rsp_beat_ff.slot;
   assign rsp_chan.vertex_index    = rsp_beat_ff.vertex_index;
   assign rsp_chan.local_a         = rsp_beat_ff.local_a;
   assign rsp_chan.local_b         = rsp_beat_ff.local_b;
   assign rsp_chan.local_c         = rsp_beat_ff.local_c;
   assign rsp_chan.vertex_count    = rsp_beat_ff.vertex_count;
   assign rsp_chan.primitive_count = rsp_beat_ff.primitive_count;
   assign rsp_chan.meshlet_number  = rsp_beat_ff.meshlet_number;
   assign rsp_chan.last            = rsp_beat_ff.last;

endmodule

@@ design/mp_checker.sv @@
// ----------------------------------------------------------------------------
// Meshlet packer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mp_checker
   import mp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input kind_type    rsp_kind,
   input logic        rsp_last
);

   // A stalled beat stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // The result register comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A new vertex is never the final beat of a triangle.
   a_vertex_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_VERTEX |-> !rsp_last)
      else $error("vertex beat marked last");

   // The primitive always ends its triangle's beats.
   a_prim_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PRIM |-> rsp_last)
      else $error("primitive beat not marked last");

endmodule

bind meshlet_packer_top mp_checker u_mp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.kind),
   .rsp_last  (rsp_chan.last)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meshlet packer regression bench
// Drives triangle and flush beats into the packer and writes both limit
// registers between phases. Expected result beats come from a behavioral
// copy of the greedy packing rules and are compared field by field. Random
// idling, a long receiver hold-off and sender pauses move the handshakes
// across every phase of the sequencer.
// ----------------------------------------------------------------------------
module testbench;
   import mp_pkg::*;

   localparam int MAX_VERTS     = 64;
   localparam int MAX_PRIMS     = 128;
   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 3000;
   localparam int RING_SIZE     = 8;
   localparam int PRINT_LIMIT   = 100;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;

   mp_req_if req_chan ();
   mp_rsp_if rsp_chan ();

   meshlet_packer_top #(
      .MAX_VERTS (MAX_VERTS),
      .MAX_PRIMS (MAX_PRIMS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Packing state as the bench believes it to be.
   logic [VERT_W-1:0]    meshlet_verts [MAX_VERTS];
   int                   open_verts = 0;
   int                   open_prims = 0;
   logic [NUMBER_W-1:0]  meshlet_no = '0;
   logic [VCOUNT_W-1:0]  vertex_limit_reg = VERTEX_LIMIT_RESET;
   logic [PCOUNT_W-1:0]  primitive_limit_reg = PRIMITIVE_LIMIT_RESET;
   rsp_beat_type         expected_beats [$];

   int                   error_count = 0;
   bit                   send_gaps_on = 1'b0;
   bit                   rsp_stall_on = 1'b0;
   int                   hold_request = 0;
   logic [VERT_W-1:0]    recent_verts [RING_SIZE];
   int                   recent_next = 0;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle length: a short gap, or one time in ten a long one.
   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] error: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Slot of a global index among the open meshlet's vertices, or -1.
   function automatic int find_slot(input logic [VERT_W-1:0] v);
      for (int i = 0; i < open_verts; i++)
         if (meshlet_verts[i] == v)
            return i;
      return -1;
   endfunction

   // Emit the close beat of the open meshlet and start a fresh one.
   function automatic void close_meshlet(input bit is_last);
      rsp_beat_type beat;
      beat = '0;
      beat.kind            = KIND_CLOSE;
      beat.vertex_count    = VCOUNT_W'(open_verts);
      beat.primitive_count = PCOUNT_W'(open_prims);
      beat.meshlet_number  = meshlet_no;
      beat.last            = is_last;
      expected_beats.push_back(beat);
      meshlet_no = meshlet_no + 1'b1;
      open_verts = 0;
      open_prims = 0;
   endfunction

   function automatic void flush_meshlet();
      if (open_verts > 0)
         close_meshlet(1'b1);
   endfunction

   // Place one triangle: close first if it does not fit, then new vertices,
   // then the primitive as local slots.
   function automatic void pack_triangle(input logic [VERT_W-1:0] a,
                                         input logic [VERT_W-1:0] b,
                                         input logic [VERT_W-1:0] c);
      logic [VERT_W-1:0] v [3];
      int                slots [3];
      int                vmax;
      int                pmax;
      int                fresh;
      int                s;
      bit                dup;
      rsp_beat_type      beat;
      v[0] = a;
      v[1] = b;
      v[2] = c;
      vmax = vertex_limit_reg;
      pmax = primitive_limit_reg;
      if (vmax < 3) vmax = 3;
      if (vmax > MAX_VERTS) vmax = MAX_VERTS;
      if (pmax < 1) pmax = 1;
      if (pmax > MAX_PRIMS) pmax = MAX_PRIMS;

      // Distinct vertices of the triangle that the meshlet lacks.
      fresh = 0;
      for (int i = 0; i < 3; i++) begin
         dup = 1'b0;
         for (int j = 0; j < i; j++)
            if (v[j] == v[i]) dup = 1'b1;
         if (!dup && find_slot(v[i]) < 0)
            fresh++;
      end
      if (open_verts + fresh > vmax || open_prims >= pmax)
         close_meshlet(1'b0);

      for (int i = 0; i < 3; i++) begin
         s = find_slot(v[i]);
         if (s < 0 && open_verts < MAX_VERTS) begin
            s = open_verts;
            meshlet_verts[open_verts] = v[i];
            open_verts++;
            beat = '0;
            beat.kind           = KIND_VERTEX;
            beat.slot           = SLOT_OUT_W'(s);
            beat.vertex_index   = v[i];
            beat.meshlet_number = meshlet_no;
            expected_beats.push_back(beat);
         end
         slots[i] = (s < 0) ? 0 : s;
      end
      beat = '0;
      beat.kind           = KIND_PRIM;
      beat.local_a        = SLOT_OUT_W'(slots[0]);
      beat.local_b        = SLOT_OUT_W'(slots[1]);
      beat.local_c        = SLOT_OUT_W'(slots[2]);
      beat.meshlet_number = meshlet_no;
      beat.last           = 1'b1;
      expected_beats.push_back(beat);
      open_prims++;
   endfunction

   // Offer one input beat, wait for its handshake, then predict its results.
   // Valid stays high afterwards so back-to-back beats need no extra edge.
   task automatic send_beat(input action_type act, input logic [VERT_W-1:0] a,
                            input logic [VERT_W-1:0] b,
                            input logic [VERT_W-1:0] c);
      int gap;
      gap = 0;
      if (send_gaps_on && $urandom_range(0, 3) == 0)
         gap = gap_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.vert_a <= a;
      req_chan.vert_b <= b;
      req_chan.vert_c <= c;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      if (act == ACT_FLUSH)
         flush_meshlet();
      else
         pack_triangle(a, b, c);
   endtask

   task automatic send_tri(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b,
                           input logic [VERT_W-1:0] c);
      send_beat(ACT_TRIANGLE, a, b, c);
      recent_verts[recent_next] = a;
      recent_verts[(recent_next + 1) % RING_SIZE] = b;
      recent_verts[(recent_next + 2) % RING_SIZE] = c;
      recent_next = (recent_next + 3) % RING_SIZE;
   endtask

   // The vertex fields of a flush carry noise; the block ignores them.
   task automatic send_flush();
      send_beat(ACT_FLUSH, $urandom(), $urandom(), $urandom());
   endtask

   // Pause the sender until every expected beat is back and the block has
   // had time to finish an input that produces nothing.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both limit registers on back-to-back edges.
   task automatic set_limits(input logic [CSR_DATA_W-1:0] vdata,
                             input logic [CSR_DATA_W-1:0] pdata);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_VERTEX_LIMIT;
      csr_write_data   <= vdata;
      @(posedge clock);
      vertex_limit_reg = vdata[VCOUNT_W-1:0];
      csr_index        <= CSR_PRIMITIVE_LIMIT;
      csr_write_data   <= pdata;
      @(posedge clock);
      primitive_limit_reg = pdata[PCOUNT_W-1:0];
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Extreme indices, repeated vertices in every position, flushes of a non-empty
   // and of an empty meshlet.
   task automatic test_field_extremes();
      send_gaps_on = 1'b0;
      rsp_stall_on = 1'b0;
      send_tri(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      send_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_tri(32'd5, 32'd5, 32'd7);
      send_tri(32'd9, 32'd8, 32'd8);
      send_tri(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000);
      send_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
      send_flush();
      send_flush();
      send_tri(32'd0, 32'd1, 32'd2);
      send_flush();
      wait_idle();
   endtask

   // Limits outside their range saturate; both limits force closes.
   task automatic test_limit_saturation();
      rsp_stall_on = 1'b1;
      set_limits(8'h00, 8'h00);
      send_tri(32'd10, 32'd11, 32'd12);
      send_tri(32'd10, 32'd11, 32'd12);
      send_tri(32'd13, 32'd13, 32'd14);
      send_flush();
      wait_idle();
      set_limits(8'd2, 8'hFF);
      send_tri(32'd1, 32'd2, 32'd3);
      send_tri(32'd1, 32'd2, 32'd4);
      send_tri(32'd4, 32'd5, 32'd5);
      wait_idle();
      set_limits(8'hFF, 8'd130);
      send_tri(32'd20, 32'd21, 32'd22);
      send_flush();
      wait_idle();
   endtask

   // Lowering the limits under an open meshlet closes it at the next
   // triangle with its larger counts.
   task automatic test_limit_lowered();
      rsp_stall_on = 1'b0;
      set_limits(8'd64, 8'd126);
      for (int i = 0; i < 6; i++)
         send_tri($urandom(), $urandom(), $urandom());
      wait_idle();
      set_limits(8'd3, 8'd2);
      send_tri(recent_verts[0], recent_verts[1], 32'd77);
      send_tri(32'd77, 32'd77, 32'd77);
      send_tri(32'd77, 32'd78, 32'd77);
      send_flush();
      wait_idle();
   endtask

   // Strips and fans with random content, mixed with fresh triangles, reuse
   // of recent vertices and flushes; each phase runs under its own limits,
   // and some phases leave a meshlet open across the limit change.
   task automatic test_random_mix();
      logic [VERT_W-1:0] sa;
      logic [VERT_W-1:0] sb;
      logic [VERT_W-1:0] hub;
      logic [VERT_W-1:0] nv;
      int                fresh_pct;
      int                pick;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_limits(8'd64, 8'd128);
            1: set_limits(CSR_DATA_W'($urandom_range(3, 64)),
                          CSR_DATA_W'($urandom_range(1, 128)));
            2: set_limits(8'd3, CSR_DATA_W'($urandom_range(1, 128)));
            3: set_limits(CSR_DATA_W'($urandom_range(3, 64)), 8'd1);
            default: set_limits(CSR_DATA_W'($urandom_range(0, 255)),
                                CSR_DATA_W'($urandom_range(0, 255)));
         endcase
         send_gaps_on = (phase != 0);
         rsp_stall_on = (phase != 1);
         fresh_pct    = (phase == 0) ? 70 : 20;
         sa  = $urandom();
         sb  = $urandom();
         hub = sa;
         repeat (18) begin
            nv = $urandom();
            if ($urandom_range(0, 99) < fresh_pct) begin
               send_tri(nv, $urandom(), $urandom());
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 55) begin
                  // Strip step in one of three rotations.
                  case ($urandom_range(0, 2))
                     0: send_tri(sa, sb, nv);
                     1: send_tri(sb, nv, sa);
                     default: send_tri(nv, sa, sb);
                  endcase
                  sa = sb;
                  sb = nv;
               end else if (pick < 70) begin
                  send_tri(hub, sb, nv);
                  sb = nv;
               end else if (pick < 90) begin
                  send_tri(recent_verts[$urandom_range(0, RING_SIZE - 1)],
                           recent_verts[$urandom_range(0, RING_SIZE - 1)],
                           recent_verts[$urandom_range(0, RING_SIZE - 1)]);
               end else begin
                  send_flush();
               end
            end
         end
         if ($urandom_range(0, 1) == 0)
            send_flush();
         wait_idle();
      end
   endtask

   // A handful of vertices reused until the widest primitive limit closes.
   task automatic test_primitive_ceiling();
      logic [VERT_W-1:0] pool [4];
      for (int i = 0; i < 4; i++)
         pool[i] = $urandom();
      send_gaps_on = 1'b1;
      rsp_stall_on = 1'b1;
      set_limits(8'd64, 8'd128);
      repeat (130)
         send_tri(pool[$urandom_range(0, 3)], pool[$urandom_range(0, 3)],
                  pool[$urandom_range(0, 3)]);
      send_flush();
      wait_idle();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering beats, so the block backs up into its input.
   task automatic test_backpressure();
      logic [VERT_W-1:0] sa;
      logic [VERT_W-1:0] sb;
      logic [VERT_W-1:0] nv;
      send_gaps_on = 1'b0;
      rsp_stall_on = 1'b0;
      set_limits(8'd16, 8'd6);
      hold_request = 300;
      sa = $urandom();
      sb = $urandom();
      repeat (20) begin
         nv = $urandom();
         send_tri(sa, sb, nv);
         sa = sb;
         sb = nv;
      end
      send_flush();
      wait_idle();
   endtask

   // Result receiver: random stalls plus an occasional long hold-off.
   initial begin
      int stall_left = 0;
      int hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
            stall_left = gap_len() - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted result beat with the oldest expectation.
   initial begin
      rsp_beat_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (expected_beats.size() == 0) begin
               report_error($sformatf("result beat with nothing expected, kind %0d",
                                      rsp_chan.kind));
            end else begin
               want = expected_beats.pop_front();
               check_field("kind", rsp_chan.kind, want.kind);
               check_field("slot", rsp_chan.slot, want.slot);
               check_field("vertex_index", rsp_chan.vertex_index, want.vertex_index);
               check_field("local_a", rsp_chan.local_a, want.local_a);
               check_field("local_b", rsp_chan.local_b, want.local_b);
               check_field("local_c", rsp_chan.local_c, want.local_c);
               check_field("vertex_count", rsp_chan.vertex_count, want.vertex_count);
               check_field("primitive_count", rsp_chan.primitive_count,
                           want.primitive_count);
               check_field("meshlet_number", rsp_chan.meshlet_number,
                           want.meshlet_number);
               check_field("last", rsp_chan.last, want.last);
            end
         end
      end
   end

   // Watchdog: too many cycles without any beat on either channel.
   initial begin
      int quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("meshlet_packer_top regression: fail");
            $finish;
         end
      end
   end

   // Reset, the test sequence and the verdict.
   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_VERTEX_LIMIT;
      csr_write_data   <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.action  <= ACT_TRIANGLE;
      req_chan.vert_a  <= '0;
      req_chan.vert_b  <= '0;
      req_chan.vert_c  <= '0;
      for (int i = 0; i < RING_SIZE; i++)
         recent_verts[i] = i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_limit_saturation();
      test_limit_lowered();
      test_random_mix();
      test_primitive_ceiling();
      test_backpressure();

      if (expected_beats.size() != 0)
         report_error($sformatf("%0d expected beats never arrived",
                                expected_beats.size()));
      if (error_count == 0)
         $display("meshlet_packer_top regression: pass");
      else
         $display("meshlet_packer_top regression: fail");
      $finish;
   end

endmodule
